// ----- src/nns_pkg.sv -----
// Shared types and constants for the nearest neighbour search block.
`default_nettype none
package nns_pkg;

    // Mode codes as they arrive in the input tuser field.
    localparam int MODE_W = 2;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // Commands that travel from the front end to the search engine.
    typedef enum logic [MODE_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_QUERY = 2'd2
    } t_op;

    // Result field widths.
    localparam int IDX_OUT_W = 10;
    localparam int DIST_W    = 50;

    // Per-axis magnitude that is squared without saturation.
    localparam int MAG_W     = 25;
    // Wide enough for the magnitude of any coordinate difference.
    localparam int MAG_EXT_W = 34;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

endpackage
`default_nettype wire

// ----- src/nns_front.sv -----
// Input front end: takes stream words, drops unused modes, holds one command.
`default_nettype none
module nns_front #(
    parameter int COORD_BITS = 24
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_tvalid,
    output logic                                o_tready,
    input  wire  [nns_pkg::MODE_W-1:0]          i_mode,
    input  wire  [3*COORD_BITS-1:0]             i_pos,
    output logic                                o_valid,
    input  wire                                 i_ready,
    output nns_pkg::t_op                        o_op,
    output logic [3*COORD_BITS-1:0]             o_pos
);

    logic                    r_valid;
    nns_pkg::t_op            r_op;
    logic [3*COORD_BITS-1:0] r_pos;
    logic                    w_accept;

    assign o_tready = !r_valid || i_ready;
    assign w_accept = i_tvalid && o_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (r_valid && i_ready) begin
                r_valid <= 1'b0;
            end
            if (w_accept) begin
                // mode 3 words are consumed and discarded
                r_valid <= (i_mode != nns_pkg::MODE_UNUSED);
                r_op    <= nns_pkg::t_op'(i_mode);
                r_pos   <= i_pos;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_op    = r_op;
    assign o_pos   = r_pos;

endmodule
`default_nettype wire

// ----- src/nns_queue.sv -----
// Small FIFO between the front end and the search engine.
`default_nettype none
module nns_queue #(
    parameter int WIDTH = 74,
    parameter int DEPTH = 4
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    input  wire  [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  wire              i_ready,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W:0]   r_wr_ptr;
    logic [PTR_W:0]   r_rd_ptr;
    logic             w_empty;
    logic             w_full;
    logic             w_push;
    logic             w_pop;

    assign w_empty = (r_wr_ptr == r_rd_ptr);
    assign w_full  = (r_wr_ptr[PTR_W-1:0] == r_rd_ptr[PTR_W-1:0]) &&
                     (r_wr_ptr[PTR_W] != r_rd_ptr[PTR_W]);
    assign o_ready = !w_full;
    assign o_valid = !w_empty;
    assign w_push  = i_valid && !w_full;
    assign w_pop   = i_ready && !w_empty;
    assign o_data  = r_mem[r_rd_ptr[PTR_W-1:0]];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr[PTR_W-1:0]] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ----- src/nns_back.sv -----
// Search engine: point memory, count, scan pipeline and result register.
`default_nettype none
module nns_back #(
    parameter int MAX_POINTS = 1024,
    parameter int COORD_BITS = 24
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cmd_valid,
    output logic                                o_cmd_ready,
    input  nns_pkg::t_op                        i_cmd_op,
    input  wire  [3*COORD_BITS-1:0]             i_cmd_pos,
    output logic                                o_res_valid,
    input  wire                                 i_res_ready,
    output logic [nns_pkg::IDX_OUT_W-1:0]       o_res_index,
    output logic [nns_pkg::DIST_W-1:0]          o_res_dist,
    output logic                                o_res_found
);

    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int PT_W   = 3 * COORD_BITS;
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int MAG_W  = nns_pkg::MAG_W;
    localparam int EXT_W  = nns_pkg::MAG_EXT_W;
    localparam int DIST_W = nns_pkg::DIST_W;
    localparam int OUT_W  = nns_pkg::IDX_OUT_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_count;
    logic [IDX_W-1:0]   r_addr;
    logic [PT_W-1:0]    r_qry;
    logic               r_res_valid;
    logic [OUT_W-1:0]   r_res_index;
    logic [DIST_W-1:0]  r_res_dist;
    logic               r_res_found;

    logic [PT_W-1:0]    r_mem [MAX_POINTS];
    logic [PT_W-1:0]    r_rd_data;

    // scan pipeline: read, magnitude, square, sum, compare
    logic               r_v1, r_f1, r_l1;
    logic [IDX_W-1:0]   r_i1;
    logic               r_v2, r_f2, r_l2;
    logic [IDX_W-1:0]   r_i2;
    logic [MAG_W-1:0]   r_mag2 [3];
    logic               r_ovf2 [3];
    logic               r_v3, r_f3, r_l3;
    logic [IDX_W-1:0]   r_i3;
    logic [DIST_W-1:0]  r_sq3 [3];
    logic               r_v4, r_f4, r_l4;
    logic [IDX_W-1:0]   r_i4;
    logic [DIST_W-1:0]  r_sum4;
    logic [DIST_W-1:0]  r_best;
    logic [IDX_W-1:0]   r_best_idx;

    logic               w_cmd_fire;
    logic               w_has_room;
    logic               w_we;
    logic               w_addr_last;
    logic [MAG_W-1:0]   w_mag [3];
    logic               w_ovf [3];
    logic [DIST_W-1:0]  w_sq [3];
    logic [DIST_W+1:0]  w_sum;
    logic               w_take;
    logic [DIST_W-1:0]  w_best;
    logic [IDX_W-1:0]   w_best_idx;
    logic [OUT_W+IDX_W-1:0] w_idx_ext;

    // a query must not start while the previous result is still waiting
    assign o_cmd_ready = (r_state == ST_IDLE) &&
                         !((i_cmd_op == nns_pkg::OP_QUERY) && r_res_valid);
    assign w_cmd_fire  = i_cmd_valid && o_cmd_ready;
    assign w_has_room  = (r_count < CNT_W'(MAX_POINTS));
    assign w_we        = w_cmd_fire && (i_cmd_op == nns_pkg::OP_LOAD) && w_has_room;
    assign w_addr_last = ((CNT_W'(r_addr) + 1'b1) == r_count);

    // point memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_count[IDX_W-1:0]] <= i_cmd_pos;
        end
        r_rd_data <= r_mem[r_addr];
    end

    // per-axis |stored - query|, flagged when its square would not fit
    always_comb begin
        logic [COORD_BITS-1:0] ca;
        logic [COORD_BITS-1:0] cb;
        logic [DIFF_W-1:0]     diff;
        logic [DIFF_W-1:0]     mag;
        logic [EXT_W-1:0]      ext;
        for (int k = 0; k < 3; k++) begin
            ca   = r_rd_data[k*COORD_BITS +: COORD_BITS];
            cb   = r_qry[k*COORD_BITS +: COORD_BITS];
            diff = {ca[COORD_BITS-1], ca} - {cb[COORD_BITS-1], cb};
            mag  = diff[DIFF_W-1] ? (~diff + 1'b1) : diff;
            ext  = EXT_W'(mag);
            w_mag[k] = ext[MAG_W-1:0];
            w_ovf[k] = |ext[EXT_W-1:MAG_W];
        end
    end

    always_comb begin
        logic [2*MAG_W-1:0] prod;
        for (int k = 0; k < 3; k++) begin
            prod    = r_mag2[k] * r_mag2[k];
            w_sq[k] = r_ovf2[k] ? nns_pkg::DIST_MAX : prod;
        end
    end

    assign w_sum = {2'b00, r_sq3[0]} + {2'b00, r_sq3[1]} + {2'b00, r_sq3[2]};

    // strict less-than keeps the earliest index on ties
    assign w_take     = r_f4 || (r_sum4 < r_best);
    assign w_best     = w_take ? r_sum4 : r_best;
    assign w_best_idx = w_take ? r_i4 : r_best_idx;
    assign w_idx_ext  = {{OUT_W{1'b0}}, w_best_idx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= (r_state == ST_SCAN);
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
        r_i1 <= r_addr;
        r_f1 <= (r_addr == '0);
        r_l1 <= w_addr_last;
        r_i2 <= r_i1;
        r_f2 <= r_f1;
        r_l2 <= r_l1;
        r_i3 <= r_i2;
        r_f3 <= r_f2;
        r_l3 <= r_l2;
        r_i4 <= r_i3;
        r_f4 <= r_f3;
        r_l4 <= r_l3;
        for (int k = 0; k < 3; k++) begin
            r_mag2[k] <= w_mag[k];
            r_ovf2[k] <= w_ovf[k];
            r_sq3[k]  <= w_sq[k];
        end
        r_sum4 <= (w_sum > {2'b00, nns_pkg::DIST_MAX}) ? nns_pkg::DIST_MAX
                                                       : w_sum[DIST_W-1:0];
        if (r_v4) begin
            r_best     <= w_best;
            r_best_idx <= w_best_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_addr      <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (r_res_valid && i_res_ready) begin
                r_res_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_cmd_fire) begin
                        unique case (i_cmd_op)
                            nns_pkg::OP_CLEAR: begin
                                r_count <= '0;
                            end
                            nns_pkg::OP_LOAD: begin
                                if (w_has_room) begin
                                    r_count <= r_count + 1'b1;
                                end
                            end
                            nns_pkg::OP_QUERY: begin
                                r_qry  <= i_cmd_pos;
                                r_addr <= '0;
                                if (r_count == '0) begin
                                    r_res_valid <= 1'b1;
                                    r_res_index <= '0;
                                    r_res_dist  <= '0;
                                    r_res_found <= 1'b0;
                                end else begin
                                    r_state <= ST_SCAN;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_SCAN: begin
                    r_addr <= r_addr + 1'b1;
                    if (w_addr_last) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (r_v4 && r_l4) begin
                        r_res_valid <= 1'b1;
                        r_res_index <= w_idx_ext[OUT_W-1:0];
                        r_res_dist  <= w_best;
                        r_res_found <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res_index = r_res_index;
    assign o_res_dist  = r_res_dist;
    assign o_res_found = r_res_found;

endmodule
`default_nettype wire

// ----- src/nearest_neighbour_search.sv -----
// Top level of the brute-force nearest neighbour search block.
`default_nettype none
// Brute-force nearest neighbour search over a stored point cloud. Each input
// word carries a mode in tuser (clear, load, query) and a 3D point in tdata.
// Clear and load words are handled in the idle state of the search engine; a
// query scans the stored points one per cycle through the single read port of
// the point memory and returns one result word, which on an empty store is
// set without a scan. Ties go to the earliest loaded point; loads beyond
// MAX_POINTS are dropped. A four-word queue plus a holding register let input
// words keep arriving during a scan, and the result register lets loads and
// clears proceed while a result waits downstream. The point memory is not
// cleared after reset; only entries below the current count are ever used.
module nearest_neighbour_search #(
    parameter int MAX_POINTS = 1024,
    parameter int COORD_BITS = 24
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // [COORD_BITS-1:0] pos_x, then pos_y, then pos_z, zero padded to bytes
    input  wire  [((3*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    // [1:0] mode
    input  wire  [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // [9:0] nearest_index, [59:10] nearest_sq_distance, [63:60] zero
    output logic [63:0] m_axis_tdata,
    // [0] found
    output logic [0:0]  m_axis_tuser
);

    localparam int PT_W    = 3 * COORD_BITS;
    localparam int OP_W    = nns_pkg::MODE_W;
    localparam int Q_W     = PT_W + OP_W;
    localparam int Q_DEPTH = 4;
    localparam int OUT_W   = nns_pkg::IDX_OUT_W;
    localparam int DIST_W  = nns_pkg::DIST_W;

    logic               w_f_valid;
    logic               w_f_ready;
    nns_pkg::t_op       w_f_op;
    logic [PT_W-1:0]    w_f_pos;
    logic               w_q_valid;
    logic               w_q_ready;
    logic [Q_W-1:0]     w_q_data;
    nns_pkg::t_op       w_q_op;
    logic [OUT_W-1:0]   w_res_index;
    logic [DIST_W-1:0]  w_res_dist;
    logic               w_res_found;

    nns_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_mode   (s_axis_tuser),
        .i_pos    (s_axis_tdata[PT_W-1:0]),
        .o_valid  (w_f_valid),
        .i_ready  (w_f_ready),
        .o_op     (w_f_op),
        .o_pos    (w_f_pos)
    );

    nns_queue #(
        .WIDTH (Q_W),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_data  ({w_f_op, w_f_pos}),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_data  (w_q_data)
    );

    assign w_q_op = nns_pkg::t_op'(w_q_data[PT_W +: OP_W]);

    nns_back #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_q_valid),
        .o_cmd_ready (w_q_ready),
        .i_cmd_op    (w_q_op),
        .i_cmd_pos   (w_q_data[PT_W-1:0]),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res_index (w_res_index),
        .o_res_dist  (w_res_dist),
        .o_res_found (w_res_found)
    );

    assign m_axis_tdata = {{(64-OUT_W-DIST_W){1'b0}}, w_res_dist, w_res_index};
    assign m_axis_tuser = w_res_found;

    // an empty-store result carries all-zero data
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("not-found result with nonzero data");

    // a query never starts while an earlier result is still pending
    a_query_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q_valid && w_q_ready && (w_q_op == nns_pkg::OP_QUERY)) |-> !m_axis_tvalid)
        else $error("query issued over a pending result");

    // an empty queue always has room
    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_q_valid |-> w_f_ready)
        else $error("queue reports full while empty");

endmodule
`default_nettype wire
